[hw/rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for signed integer to decimal text
// Widths of the binary and packed-BCD words, ASCII codes and the helper
// that finds the leading decimal digit.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned BIN_W   = 32;
    localparam int unsigned DIGITS  = 10;
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned IDX_W   = $clog2(DIGITS);
    localparam int unsigned STEP_W  = $clog2(BIN_W);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [BIN_W-1:0] bin_t;
    typedef logic [IDX_W-1:0] digit_idx_t;

    // Index of the most significant nonzero digit; zero when all digits are zero.
    function automatic digit_idx_t lead_index(input bcd_t bcd);
        digit_idx_t idx;
        idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[4*i +: 4] != 4'd0)
            begin
                idx = digit_idx_t'(i);
            end
        end
        return idx;
    endfunction

endpackage

[hw/rtl/sitda_stream_if.sv]
// ----------------------------------------------------------------------------
// sitda stream interfaces
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface sitda_value_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

[hw/rtl/sitda_dabble_step.sv]
// ----------------------------------------------------------------------------
// sitda_dabble_step: one shift-and-add-3 step of binary to BCD conversion
// Every BCD digit of five or more is raised by three, then the BCD and
// binary words shift left together by one bit.
// ----------------------------------------------------------------------------
module sitda_dabble_step
    import sitda_pkg::*;
(
    input  bcd_t bcd,
    input  bin_t bin,
    output bcd_t bcd_next,
    output bin_t bin_next
);

    bcd_t adjusted;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                adjusted[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
            else
            begin
                adjusted[4*i +: 4] = bcd[4*i +: 4];
            end
        end
    end

    assign bcd_next = {adjusted[BCD_W-2:0], bin[BIN_W-1]};
    assign bin_next = {bin[BIN_W-2:0], 1'b0};

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Double-dabble conversion followed by character emission.
// ----------------------------------------------------------------------------
// Each input beat carries one signed 32-bit integer. The block answers with
// its decimal text, one ASCII character per output beat, most significant
// character first: a '-' for a negative value, then the digits with no
// leading zeros (zero gives the single character '0'). The final beat of a
// number has last set. The most negative value converts correctly because
// the magnitude is held as an unsigned 32-bit word. After a beat is accepted
// the block runs its shift-and-add-3 unit over the magnitude, one bit per
// cycle, then presents one character per cycle while the output is taken.
// The input is ready only while no number is being worked on; the last
// character may still sit in the output register when the next number is
// accepted.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sitda_value_if.sink     in_ch,
    sitda_char_if.source    out_ch
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic               sign_pending_reg;
    bin_t               mag_reg;
    bcd_t               bcd_reg;
    digit_idx_t         idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               out_last_reg;

    bcd_t               bcd_step;
    bin_t               mag_step;
    logic               in_accept;
    logic               out_load;
    logic [3:0]         cur_digit;

    // The shared conversion unit works on the held BCD and magnitude words.
    sitda_dabble_step u_step
    (
        .bcd      (bcd_reg),
        .bin      (mag_reg),
        .bcd_next (bcd_step),
        .bin_next (mag_step)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    // The output register takes a new character when it is empty or draining.
    assign out_load    = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);
    assign cur_digit   = bcd_reg[4*idx_reg +: 4];

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.character = out_char_reg;
    assign out_ch.last      = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            sign_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        neg_reg   <= in_ch.value[BIN_W-1];
                        // Two's complement negate as an unsigned word keeps
                        // the most negative value exact.
                        mag_reg   <= in_ch.value[BIN_W-1] ? (bin_t'(0) - bin_t'(in_ch.value))
                                                          : bin_t'(in_ch.value);
                        bcd_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_CONVERT;
                    end
                end

                ST_CONVERT:
                begin
                    bcd_reg  <= bcd_step;
                    mag_reg  <= mag_step;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(BIN_W - 1))
                    begin
                        idx_reg          <= lead_index(bcd_step);
                        sign_pending_reg <= neg_reg;
                        state_reg        <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        if (sign_pending_reg)
                        begin
                            out_char_reg     <= CHAR_MINUS;
                            out_last_reg     <= 1'b0;
                            sign_pending_reg <= 1'b0;
                        end
                        else
                        begin
                            out_char_reg <= CHAR_ZERO + {4'd0, cur_digit};
                            out_last_reg <= (idx_reg == '0);
                            if (idx_reg == '0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg - 1'b1;
                            end
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // An accepted number always starts a full conversion from step zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_CONVERT) && (step_reg == '0))
        else $error("conversion did not start after input beat");

    // Every digit that reaches the output is a valid decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !sign_pending_reg) |-> (cur_digit <= 4'd9))
        else $error("conversion produced a non-decimal digit");

    // The sign character never ends a number's text.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_char_reg == CHAR_MINUS) |-> !out_last_reg)
        else $error("minus sign flagged as last character");

endmodule
